### hw/rtl/sre_pkg.sv
// Package: shared types and constants for the sensor rate estimator.
package sre_pkg;

  localparam int TS_W    = 48;
  localparam int COUNT_W = 24;
  localparam int AGREE_W = 16;
  localparam int RATE_W  = 16;
  localparam int BUF_W   = 16;
  localparam int EL_W    = 18;
  localparam int CFG_W   = 18;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_WINDOW_LEN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_WINDOW  = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_SAMPLES = 3'd2;
  localparam logic [IDX_W-1:0] REG_AGREE_NEED  = 3'd3;
  localparam logic [IDX_W-1:0] REG_INIT_RATE   = 3'd4;
  localparam logic [IDX_W-1:0] REG_INIT_BUF    = 3'd5;

  // Datapath operations requested by the controller.
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_ACCEPT  = 4'd1,  // latch item, apply clear/open/count, compute elapsed
    OP_EVAL    = 4'd2,  // classify window, load rate division
    OP_DIV     = 4'd3,  // one divider step
    OP_MEAS    = 4'd4,  // take quotient, load mean-step division
    OP_CAND    = 4'd5,  // fold candidate
    OP_DEV     = 4'd6,  // deviation check, load buffer division
    OP_BUF     = 4'd7   // commit rate and buffer
  } op_t;

  typedef struct packed {
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic stop;      // item finishes without a rate measurement
    logic no_update; // measurement taken, no rate change
  } sts_t;

endpackage

### hw/rtl/sre_ctrl.sv
// Controller: sequences one item through the datapath.
module sre_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  sre_pkg::sts_t sts,
  output sre_pkg::cmd_t cmd
);
  import sre_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_EVAL = 10'b0000000010,
    S_CHK  = 10'b0000000100,
    S_DIV1 = 10'b0000001000,
    S_MEAS = 10'b0000010000,
    S_DIV2 = 10'b0000100000,
    S_CAND = 10'b0001000000,
    S_DEV  = 10'b0010000000,
    S_DIV3 = 10'b0100000000,
    S_BUF  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.stop) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.op    = OP_EVAL;
          state_nxt = S_CHK;
        end
      end
      // window still short or discarded: no measurement
      S_CHK: begin
        if (sts.stop) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd.op = OP_DIV;
        if (sts.div_done) state_nxt = S_MEAS;
      end
      S_MEAS: begin
        cmd.op    = OP_MEAS;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        cmd.op = OP_DIV;
        if (sts.div_done) state_nxt = S_CAND;
      end
      S_CAND: begin
        cmd.op    = OP_CAND;
        state_nxt = S_DEV;
      end
      S_DEV: begin
        if (sts.no_update) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.op    = OP_DEV;
          state_nxt = S_DIV3;
        end
      end
      S_DIV3: begin
        cmd.op = OP_DIV;
        if (sts.div_done) state_nxt = S_BUF;
      end
      S_BUF: begin
        cmd.op        = OP_BUF;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

### hw/rtl/sre_dp.sv
// Datapath: window state, shared restoring divider, candidate and rate registers.
module sre_dp #(
  parameter int RATE_FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sre_pkg::cmd_t               cmd,
  output sre_pkg::sts_t               sts,
  input  logic                        in_kind,
  input  logic [sre_pkg::TS_W-1:0]    in_timestamp_ms,
  input  logic                        cfg_we,
  input  logic [sre_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sre_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                        out_rate_changed,
  output logic [sre_pkg::RATE_W-1:0]  out_new_rate_hz,
  output logic [sre_pkg::BUF_W-1:0]   out_new_buffer_size
);
  import sre_pkg::*;

  localparam int CAND_W = RATE_W + RATE_FRAC_BITS;
  // numerator count*1000*2^F*2 + elapsed: 24+10+F+1 bits plus carry
  localparam int NUM_W  = COUNT_W + 10 + RATE_FRAC_BITS + 2;
  localparam int DEN_W  = 2 * RATE_W + 1;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam logic [CAND_W-1:0] CAND_MAX = {CAND_W{1'b1}};
  localparam logic [CAND_W-1:0] HALF = CAND_W'(1) << (RATE_FRAC_BITS - 1);

  // configuration
  logic [15:0] win_len_r;
  logic [17:0] max_win_r;
  logic [15:0] min_samp_r;
  logic [7:0]  agree_need_r;

  logic               open_r;
  logic [TS_W-1:0]    start_r;
  logic [COUNT_W-1:0] count_r;
  logic [CAND_W-1:0]  cand_r;
  logic [AGREE_W-1:0] agree_r;
  logic [RATE_W-1:0]  rate_r;
  logic [BUF_W-1:0]   buf_r;
  logic               changed_r;

  logic [TS_W-1:0]    elapsed_r;
  logic [TS_W-1:0]    ts_r;
  logic               stop_r;
  logic [CAND_W-1:0]  meas_r;
  logic               up_r;
  logic [RATE_W-1:0]  newrate_r;

  // shared serial divider
  logic [NUM_W-1:0]   quo_r;
  logic [DEN_W:0]     rem_r;
  logic [DEN_W-1:0]   den_r;
  logic [CNT_W-1:0]   cnt_r;

  logic [DEN_W:0]     trial;
  assign trial = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]} - {1'b0, den_r};

  // combinational helpers
  logic [COUNT_W-1:0] count_inc;
  logic [NUM_W-1:0]   num_rate;
  logic [CAND_W-1:0]  meas_c;
  logic [CAND_W-1:0]  mdiff_c;
  logic [CAND_W-1:0]  ad_c;
  logic               agree_ok;
  logic [CAND_W+4:0]  ad20;
  logic [CAND_W-1:0]  cand_nxt;
  logic [CAND_W-1:0]  refq;
  logic [CAND_W-1:0]  dev;
  logic [CAND_W+3:0]  dev10;
  logic [CAND_W:0]    rnd;
  logic [RATE_W-1:0]  rnd_sat;
  logic [DEN_W-1:0]   bprod;
  logic [NUM_W-1:0]   q_sat;

  assign count_inc = (count_r == {COUNT_W{1'b1}}) ? count_r : count_r + 1'b1;
  assign num_rate  = (NUM_W'(count_r) * NUM_W'(1000) << (RATE_FRAC_BITS + 1))
                     + NUM_W'(elapsed_r[EL_W-1:0]);
  assign q_sat     = quo_r;
  assign meas_c    = (q_sat > NUM_W'(CAND_MAX)) ? CAND_MAX : q_sat[CAND_W-1:0];
  assign mdiff_c   = (meas_c >= cand_r) ? meas_c - cand_r : cand_r - meas_c;
  assign ad_c      = (meas_r >= cand_r) ? meas_r - cand_r : cand_r - meas_r;
  assign ad20      = (CAND_W+5)'(ad_c) * (CAND_W+5)'(20);
  assign agree_ok  = (agree_r != '0) && (ad20 <= (CAND_W+5)'(cand_r));
  assign cand_nxt  = up_r ? cand_r + quo_r[CAND_W-1:0] : cand_r - quo_r[CAND_W-1:0];
  assign refq      = CAND_W'(rate_r) << RATE_FRAC_BITS;
  assign dev       = (cand_r >= refq) ? cand_r - refq : refq - cand_r;
  assign dev10     = (CAND_W+4)'(dev) * (CAND_W+4)'(10);
  assign rnd       = ((CAND_W+1)'(cand_r) + (CAND_W+1)'(HALF)) >> RATE_FRAC_BITS;
  assign rnd_sat   = (rnd > (CAND_W+1)'(16'hFFFF)) ? 16'hFFFF : rnd[RATE_W-1:0];
  assign bprod     = DEN_W'(buf_r) * DEN_W'(rnd_sat);

  always_comb begin
    sts.div_done  = (cnt_r == '0);
    sts.stop      = stop_r;
    sts.no_update = (agree_r < AGREE_W'(agree_need_r))
                    || (dev10 <= (CAND_W+4)'(refq))
                    || (rnd_sat == '0) || (rnd_sat == rate_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r    <= 16'd1000;
      max_win_r    <= 18'd3000;
      min_samp_r   <= 16'd10;
      agree_need_r <= 8'd3;
      rate_r       <= '0;
      buf_r        <= 16'd1;
      open_r       <= 1'b0;
      count_r      <= '0;
      cand_r       <= '0;
      agree_r      <= '0;
      changed_r    <= 1'b0;
      stop_r       <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_LEN:  win_len_r    <= cfg_wdata[15:0];
          REG_MAX_WINDOW:  max_win_r    <= cfg_wdata[17:0];
          REG_MIN_SAMPLES: min_samp_r   <= cfg_wdata[15:0];
          REG_AGREE_NEED:  agree_need_r <= cfg_wdata[7:0];
          REG_INIT_RATE:   rate_r       <= cfg_wdata[15:0];
          REG_INIT_BUF:    buf_r        <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_ACCEPT: begin
          changed_r <= 1'b0;
          ts_r      <= in_timestamp_ms;
          stop_r    <= 1'b1;
          if (in_kind) begin
            open_r  <= 1'b0;
            count_r <= '0;
            cand_r  <= '0;
            agree_r <= '0;
          end else if (!open_r) begin
            open_r  <= 1'b1;
            start_r <= in_timestamp_ms;
            count_r <= '0;
          end else begin
            count_r   <= count_inc;
            elapsed_r <= in_timestamp_ms - start_r;
            stop_r    <= 1'b0;
          end
        end
        OP_EVAL: begin
          // elapsed >= window length here unless stopped below
          if (elapsed_r < TS_W'(win_len_r)) begin
            stop_r <= 1'b1;
          end else begin
            start_r <= ts_r;
            count_r <= '0;
            if (elapsed_r == '0 || elapsed_r > TS_W'(max_win_r)
                || count_r < COUNT_W'(min_samp_r)) begin
              stop_r  <= 1'b1;
              cand_r  <= '0;
              agree_r <= '0;
            end else begin
              quo_r <= num_rate;
              rem_r <= '0;
              den_r <= DEN_W'({elapsed_r[EL_W-1:0], 1'b0});
              cnt_r <= CNT_W'(NUM_W);
            end
          end
        end
        OP_DIV: begin
          if (cnt_r != '0) begin
            cnt_r <= cnt_r - 1'b1;
            if (!trial[DEN_W]) begin
              rem_r <= trial;
              quo_r <= {quo_r[NUM_W-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
              quo_r <= {quo_r[NUM_W-2:0], 1'b0};
            end
          end
        end
        OP_MEAS: begin
          // take the measured rate and load the mean-step division
          meas_r <= meas_c;
          up_r   <= (meas_c >= cand_r);
          quo_r  <= NUM_W'(mdiff_c);
          rem_r  <= '0;
          den_r  <= DEN_W'(agree_r) + DEN_W'(1);
          cnt_r  <= CNT_W'(NUM_W);
        end
        OP_CAND: begin
          if (!agree_ok) begin
            cand_r  <= meas_r;
            agree_r <= AGREE_W'(1);
          end else begin
            cand_r  <= cand_nxt;
            if (agree_r != {AGREE_W{1'b1}}) agree_r <= agree_r + 1'b1;
          end
        end
        OP_DEV: begin
          newrate_r <= rnd_sat;
          if (rate_r == '0) begin
            quo_r <= NUM_W'(buf_r);
            cnt_r <= '0;
          end else begin
            quo_r <= NUM_W'({bprod, 1'b0}) + NUM_W'(rate_r);
            rem_r <= '0;
            den_r <= DEN_W'({rate_r, 1'b0});
            cnt_r <= CNT_W'(NUM_W);
          end
        end
        OP_BUF: begin
          rate_r    <= newrate_r;
          changed_r <= 1'b1;
          if (quo_r == '0) buf_r <= 16'd1;
          else if (quo_r > NUM_W'(16'hFFFF)) buf_r <= 16'hFFFF;
          else buf_r <= quo_r[BUF_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign out_rate_changed    = changed_r;
  assign out_new_rate_hz     = rate_r;
  assign out_new_buffer_size = buf_r;
endmodule

### hw/rtl/sensor_rate_estimator.sv
// Top level: sensor rate estimator.
// Each item returns one result. A clear item or a sample that opens a window
// finishes in state S_EVAL; a sample that extends a window or closes a
// discarded one finishes in S_CHK. A sample that closes a valid window runs
// the shared restoring divider (44 quotient bits) for the measured rate and the
// running-mean step, and for the buffer rescale when the rate changes; the
// rescale skips the division steps when the old rate is zero. The result sits
// in the state registers, so the next item is taken only once the result is
// transferred, at the earliest in the same cycle.
module sensor_rate_estimator #(
  parameter int RATE_FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [sre_pkg::TS_W-1:0]    in_timestamp_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_rate_changed,
  output logic [sre_pkg::RATE_W-1:0]  out_new_rate_hz,
  output logic [sre_pkg::BUF_W-1:0]   out_new_buffer_size,
  input  logic                        cfg_we,
  input  logic [sre_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sre_pkg::CFG_W-1:0]   cfg_wdata
);
  import sre_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sre_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  sre_dp #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_kind(in_kind), .in_timestamp_ms(in_timestamp_ms),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_rate_changed(out_rate_changed), .out_new_rate_hz(out_new_rate_hz),
    .out_new_buffer_size(out_new_buffer_size)
  );
endmodule
